>>> rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// Holds the request and result payload structs, codes, FSM states and control structs.
// No dependencies.
package stq_pkg;

    localparam int OP_W       = 2;
    localparam int INTERVAL_W = 31;
    localparam int KILL_ID_W  = 16;
    localparam int ELAPSED_W  = 31;
    localparam int STATUS_W   = 3;
    localparam int IDENT_W    = 16;
    localparam int TIME_W     = 32;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSTALL = 2'd0,
        OP_KILL    = 2'd1,
        OP_TICK    = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSTALLED = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_KILLED    = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EXPIRED   = 3'd4,
        STAT_NONE      = 3'd5
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [INTERVAL_W-1:0] interval;
        logic [KILL_ID_W-1:0]  kill_id;
        logic [ELAPSED_W-1:0]  elapsed;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDENT_W-1:0]  timer_ident;
        logic                last;
    } out_item_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_EX,
        S_KIL_RD,
        S_KIL_EX,
        S_TCK_RD,
        S_TCK_EX,
        S_EXP_RD,
        S_EXP_EX,
        S_RSP_INS,
        S_RSP_FULL,
        S_RSP_KILL,
        S_RSP_NONE
    } state_t;

    // Memory read address select
    typedef enum logic {
        RD_AT_IDX,
        RD_BELOW_IDX
    } rd_sel_t;

    // Memory write source and address select
    typedef enum logic [2:0] {
        WR_NEW_AT_IDX,
        WR_HELD_AT_IDX,
        WR_HELD_AT_WPTR,
        WR_AGED_AT_IDX,
        WR_HELD_DOWN
    } wr_sel_t;

    // Result kind to load into the output register
    typedef enum logic [2:0] {
        EM_INSTALLED,
        EM_FULL,
        EM_KILL,
        EM_EXPIRED,
        EM_NONE
    } emit_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      capture;
        logic      pass_start;
        logic      idx_load_count;
        logic      idx_clear;
        logic      idx_inc;
        logic      idx_dec;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        logic      wptr_inc;
        logic      exp_inc;
        logic      count_inc;
        logic      count_from_wptr;
        logic      count_drop_exp;
        logic      emit;
        emit_sel_t emit_sel;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            idx_zero;
        logic            idx_at_count;
        logic            exp_zero;
        logic            idx_in_prefix;
        logic            held_not_below;
        logic            held_match;
        logic            aged_expired;
        logic            out_free;
    } sts_t;

endpackage

>>> rtl/sorted_timer_queue.sv
// Sorted timer queue: a queue of software timers ordered by remaining time.
// Request channel s_*, result channel m_*, both valid/ready with packed payload structs.
// Depends on stq_pkg, stq_ctrl and stq_dp.
//
// Use: send one request per item. Install (operation 0) answers one result with
// the new timer id or full. Kill (1) answers one result, killed or not found,
// echoing kill_id. Tick (2) ages all entries by elapsed, saturating at the signed
// minimum, then answers one expired result per timed-out head entry in queue
// order, or a single none result; last marks the final result of a request.
// Operation code 3 is accepted and dropped with no result.
// The entry memory has one read and one write port with registered read data, so each
// entry visited takes a read state followed by an execute state. The controller works
// on one request at a time; s_ready is high only while it is idle, which may overlap a
// result still held in the output register. A stalled receiver holds the result
// register and pauses the walk at the next result. Reset clears the count and the id
// counter; the memory needs no clearing since only entries below the count are read.
module sorted_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stq_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output stq_pkg::out_item_t m_payload
);

    stq_pkg::cmd_t cmd;
    stq_pkg::sts_t sts;

    // Sequence requests
    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Store entries and build results
    stq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

>>> rtl/stq_ctrl.sv
// Controller state machine of the sorted timer queue.
// Sequences install, kill and tick requests over the entry memory one entry at a time.
// Depends on stq_pkg.
module stq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  stq_pkg::sts_t sts,
    output stq_pkg::cmd_t cmd
);

    stq_pkg::state_t state_reg;
    stq_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = stq_pkg::S_DISPATCH;
                end
            end
            stq_pkg::S_DISPATCH: begin
                case (stq_pkg::op_t'(sts.op))
                    stq_pkg::OP_INSTALL: begin
                        state_next = sts.full ? stq_pkg::S_RSP_FULL : stq_pkg::S_INS_RD;
                    end
                    stq_pkg::OP_KILL:    state_next = stq_pkg::S_KIL_RD;
                    stq_pkg::OP_TICK:    state_next = stq_pkg::S_TCK_RD;
                    default:             state_next = stq_pkg::S_IDLE;
                endcase
            end
            stq_pkg::S_INS_RD: begin
                state_next = sts.idx_zero ? stq_pkg::S_RSP_INS : stq_pkg::S_INS_EX;
            end
            stq_pkg::S_INS_EX: begin
                state_next = sts.held_not_below ? stq_pkg::S_INS_RD : stq_pkg::S_RSP_INS;
            end
            stq_pkg::S_KIL_RD: begin
                state_next = sts.idx_at_count ? stq_pkg::S_RSP_KILL : stq_pkg::S_KIL_EX;
            end
            stq_pkg::S_KIL_EX: begin
                state_next = stq_pkg::S_KIL_RD;
            end
            stq_pkg::S_TCK_RD: begin
                state_next = sts.idx_at_count ? stq_pkg::S_EXP_RD : stq_pkg::S_TCK_EX;
            end
            stq_pkg::S_TCK_EX: begin
                state_next = stq_pkg::S_TCK_RD;
            end
            stq_pkg::S_EXP_RD: begin
                if (sts.exp_zero) begin
                    state_next = stq_pkg::S_RSP_NONE;
                end else if (sts.idx_at_count) begin
                    state_next = stq_pkg::S_IDLE;
                end else begin
                    state_next = stq_pkg::S_EXP_EX;
                end
            end
            stq_pkg::S_EXP_EX: begin
                if (!sts.idx_in_prefix || sts.out_free) begin
                    state_next = stq_pkg::S_EXP_RD;
                end
            end
            stq_pkg::S_RSP_INS, stq_pkg::S_RSP_FULL, stq_pkg::S_RSP_KILL,
            stq_pkg::S_RSP_NONE: begin
                if (sts.out_free) begin
                    state_next = stq_pkg::S_IDLE;
                end
            end
            default: state_next = stq_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        cmd.rd_sel   = stq_pkg::RD_AT_IDX;
        cmd.wr_sel   = stq_pkg::WR_HELD_AT_IDX;
        cmd.emit_sel = stq_pkg::EM_NONE;
        s_ready      = 1'b0;
        case (state_reg)
            stq_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            stq_pkg::S_DISPATCH: begin
                cmd.pass_start     = 1'b1;
                cmd.idx_load_count = (stq_pkg::op_t'(sts.op) == stq_pkg::OP_INSTALL);
            end
            stq_pkg::S_INS_RD: begin
                if (sts.idx_zero) begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = stq_pkg::WR_NEW_AT_IDX;
                    cmd.count_inc = 1'b1;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = stq_pkg::RD_BELOW_IDX;
                end
            end
            stq_pkg::S_INS_EX: begin
                cmd.wr_en = 1'b1;
                if (sts.held_not_below) begin
                    cmd.wr_sel  = stq_pkg::WR_HELD_AT_IDX;
                    cmd.idx_dec = 1'b1;
                end else begin
                    cmd.wr_sel    = stq_pkg::WR_NEW_AT_IDX;
                    cmd.count_inc = 1'b1;
                end
            end
            stq_pkg::S_KIL_RD: begin
                if (sts.idx_at_count) begin
                    cmd.count_from_wptr = 1'b1;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            stq_pkg::S_KIL_EX: begin
                cmd.idx_inc = 1'b1;
                if (!sts.held_match) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = stq_pkg::WR_HELD_AT_WPTR;
                    cmd.wptr_inc = 1'b1;
                end
            end
            stq_pkg::S_TCK_RD: begin
                if (sts.idx_at_count) begin
                    cmd.idx_clear = 1'b1;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            stq_pkg::S_TCK_EX: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = stq_pkg::WR_AGED_AT_IDX;
                cmd.exp_inc = sts.aged_expired;
                cmd.idx_inc = 1'b1;
            end
            stq_pkg::S_EXP_RD: begin
                if (!sts.exp_zero && sts.idx_at_count) begin
                    cmd.count_drop_exp = 1'b1;
                end else if (!sts.exp_zero) begin
                    cmd.rd_en = 1'b1;
                end
            end
            stq_pkg::S_EXP_EX: begin
                if (sts.idx_in_prefix) begin
                    cmd.emit_sel = stq_pkg::EM_EXPIRED;
                    cmd.emit     = sts.out_free;
                    cmd.idx_inc  = sts.out_free;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = stq_pkg::WR_HELD_DOWN;
                    cmd.idx_inc = 1'b1;
                end
            end
            stq_pkg::S_RSP_INS: begin
                cmd.emit_sel = stq_pkg::EM_INSTALLED;
                cmd.emit     = sts.out_free;
            end
            stq_pkg::S_RSP_FULL: begin
                cmd.emit_sel = stq_pkg::EM_FULL;
                cmd.emit     = sts.out_free;
            end
            stq_pkg::S_RSP_KILL: begin
                cmd.emit_sel = stq_pkg::EM_KILL;
                cmd.emit     = sts.out_free;
            end
            stq_pkg::S_RSP_NONE: begin
                cmd.emit_sel = stq_pkg::EM_NONE;
                cmd.emit     = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // A result is loaded only when the output register can take it
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register busy");

    // An install never grows a full queue
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc |-> !sts.full)
        else $error("entry count raised on a full queue");

endmodule

>>> rtl/stq_dp.sv
// Datapath of the sorted timer queue: entry memory, counters, aging arithmetic
// and the output register. Driven by stq_ctrl command signals.
// Depends on stq_pkg.
module stq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  stq_pkg::in_item_t  s_payload,
    input  stq_pkg::cmd_t      cmd,
    output stq_pkg::sts_t      sts,
    output logic               m_valid,
    input  logic               m_ready,
    output stq_pkg::out_item_t m_payload
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW = stq_pkg::TIME_W;

    // Entry memory, one write and one registered read port
    logic [TW-1:0]      time_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0] id_mem   [QUEUE_DEPTH];
    logic [TW-1:0]      rd_time_reg;
    logic [ID_BITS-1:0] rd_id_reg;

    stq_pkg::in_item_t  item_reg;
    logic [CW-1:0]      count_reg;
    logic [ID_BITS-1:0] next_id_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      wptr_reg;
    logic [CW-1:0]      exp_reg;
    logic               found_reg;
    logic               out_valid_reg;
    stq_pkg::out_item_t out_item_reg;
    stq_pkg::out_item_t out_item_next;

    logic [CW-1:0]      idx_below;
    logic [CW-1:0]      rd_addr_full;
    logic [CW-1:0]      wr_addr_full;
    logic [TW-1:0]      wr_time;
    logic [ID_BITS-1:0] wr_id;
    logic [TW:0]        diff;
    logic [TW-1:0]      aged;
    logic [TW-1:0]      new_time;
    logic [31:0]        rd_id_ext;
    logic [31:0]        next_id_ext;

    assign idx_below = idx_reg - CW'(1);
    assign new_time  = {1'b0, item_reg.interval};

    // Saturating subtract of the elapsed time
    assign diff = {rd_time_reg[TW-1], rd_time_reg} - {2'b00, item_reg.elapsed};
    always_comb begin
        if (diff[TW] && !diff[TW-1]) begin
            aged = {1'b1, {(TW-1){1'b0}}};
        end else begin
            aged = diff[TW-1:0];
        end
    end

    // Select read and write addresses and write data
    assign rd_addr_full = (cmd.rd_sel == stq_pkg::RD_BELOW_IDX) ? idx_below : idx_reg;

    always_comb begin
        wr_addr_full = idx_reg;
        wr_time      = rd_time_reg;
        wr_id        = rd_id_reg;
        case (cmd.wr_sel)
            stq_pkg::WR_NEW_AT_IDX: begin
                wr_time = new_time;
                wr_id   = next_id_reg;
            end
            stq_pkg::WR_HELD_AT_IDX:  wr_addr_full = idx_reg;
            stq_pkg::WR_HELD_AT_WPTR: wr_addr_full = wptr_reg;
            stq_pkg::WR_AGED_AT_IDX:  wr_time = aged;
            stq_pkg::WR_HELD_DOWN:    wr_addr_full = idx_reg - exp_reg;
            default:                  wr_addr_full = idx_reg;
        endcase
    end

    // Write and read the entry memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            time_mem[wr_addr_full[AW-1:0]] <= wr_time;
            id_mem[wr_addr_full[AW-1:0]]   <= wr_id;
        end
        if (cmd.rd_en) begin
            rd_time_reg <= time_mem[rd_addr_full[AW-1:0]];
            rd_id_reg   <= id_mem[rd_addr_full[AW-1:0]];
        end
    end

    // Capture request, advance walk pointers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_payload;
        end
        if (cmd.pass_start) begin
            wptr_reg <= '0;
            exp_reg  <= '0;
        end else begin
            if (cmd.wptr_inc) begin
                wptr_reg <= wptr_reg + CW'(1);
            end
            if (cmd.exp_inc) begin
                exp_reg <= exp_reg + CW'(1);
            end
        end
        if (cmd.idx_load_count) begin
            idx_reg <= count_reg;
        end else if (cmd.pass_start || cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_below;
        end
        if (cmd.count_from_wptr) begin
            found_reg <= (wptr_reg != count_reg);
        end
    end

    // Track entry count and the next id
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            next_id_reg <= '0;
        end else begin
            if (cmd.count_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.count_from_wptr) begin
                count_reg <= wptr_reg;
            end else if (cmd.count_drop_exp) begin
                count_reg <= count_reg - exp_reg;
            end
            if (cmd.emit && cmd.emit_sel == stq_pkg::EM_INSTALLED) begin
                next_id_reg <= next_id_reg + ID_BITS'(1);
            end
        end
    end

    // Build the result
    assign rd_id_ext   = 32'(rd_id_reg);
    assign next_id_ext = 32'(next_id_reg);

    always_comb begin
        out_item_next.status      = stq_pkg::STAT_NONE;
        out_item_next.timer_ident = '0;
        out_item_next.last        = 1'b1;
        case (cmd.emit_sel)
            stq_pkg::EM_INSTALLED: begin
                out_item_next.status      = stq_pkg::STAT_INSTALLED;
                out_item_next.timer_ident = next_id_ext[stq_pkg::IDENT_W-1:0];
            end
            stq_pkg::EM_FULL: begin
                out_item_next.status = stq_pkg::STAT_FULL;
            end
            stq_pkg::EM_KILL: begin
                out_item_next.status      = found_reg ? stq_pkg::STAT_KILLED
                                                      : stq_pkg::STAT_NOT_FOUND;
                out_item_next.timer_ident = item_reg.kill_id;
            end
            stq_pkg::EM_EXPIRED: begin
                out_item_next.status      = stq_pkg::STAT_EXPIRED;
                out_item_next.timer_ident = rd_id_ext[stq_pkg::IDENT_W-1:0];
                out_item_next.last        = ((idx_reg + CW'(1)) == exp_reg);
            end
            default: begin
                out_item_next.status = stq_pkg::STAT_NONE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    // Status toward the controller
    always_comb begin
        sts.op             = item_reg.operation;
        sts.full           = (count_reg == CW'(QUEUE_DEPTH));
        sts.idx_zero       = (idx_reg == '0);
        sts.idx_at_count   = (idx_reg == count_reg);
        sts.exp_zero       = (exp_reg == '0);
        sts.idx_in_prefix  = (idx_reg < exp_reg);
        sts.held_not_below = ($signed(rd_time_reg) >= $signed(new_time));
        sts.held_match     = (rd_id_ext == 32'(item_reg.kill_id));
        sts.aged_expired   = aged[TW-1] || (aged == '0);
        sts.out_free       = !out_valid_reg || m_ready;
    end

    // Every write lands inside the memory
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (wr_addr_full < CW'(QUEUE_DEPTH)))
        else $error("entry write outside the queue");

    // The entry count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // Each installed result advances the id by one
    a_id_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_sel == stq_pkg::EM_INSTALLED)
        |=> next_id_reg == $past(next_id_reg) + ID_BITS'(1))
        else $error("next id did not advance after install");

endmodule

>>> bench/sorted_timer_queue_tb.sv
// Self-checking bench for sorted_timer_queue: install, kill and tick requests go in over
// valid/ready, a shadow timer queue predicts every result, and the monitor compares them.
// Depends on stq_pkg and the sorted_timer_queue RTL.
module sorted_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DEPTH       = 16;
    localparam int     ID_W        = 16;
    localparam int     IV_W        = stq_pkg::INTERVAL_W;
    localparam int     KL_W        = stq_pkg::KILL_ID_W;
    localparam int     EL_W        = stq_pkg::ELAPSED_W;
    localparam int     SETTLE      = 200;
    localparam int     LONG_HOLD   = 600;
    localparam int     MAX_REPORTS = 10;
    localparam longint CYCLE_LIMIT = 8_000_000;
    localparam longint TIME_FLOOR  = -(longint'(1) << 31);

    localparam logic [IV_W-1:0] INTERVAL_MAX = '1;
    localparam logic [EL_W-1:0] ELAPSED_MAX  = '1;
    localparam logic [KL_W-1:0] KILL_ID_MAX  = '1;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    stq_pkg::in_item_t  s_payload = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    stq_pkg::out_item_t m_payload;

    sorted_timer_queue #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (ID_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    // Shadow copy of the timer queue, updated as each request is accepted
    int              shadow_remaining [DEPTH];
    logic [ID_W-1:0] shadow_ident [DEPTH];
    int              shadow_count   = 0;
    logic [ID_W-1:0] shadow_next_id = '0;

    stq_pkg::in_item_t  request_queue [$];
    stq_pkg::out_item_t pending_results [$];

    int              sender_idle_pct  = 0;
    int              result_stall_pct = 0;
    logic            hold_trigger     = 1'b0;
    int              hold_left        = 0;
    logic [ID_W-1:0] guess_next_id    = '0;
    logic [IV_W-1:0] recent_interval  = '0;

    int     accepted_requests = 0;
    int     checked_results   = 0;
    int     full_answers      = 0;
    int     expiries          = 0;
    int     mismatch_count    = 0;
    longint cycle_count       = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Random field values at the field widths
    function automatic logic [IV_W-1:0] rand_interval();
        return IV_W'($urandom);
    endfunction

    function automatic logic [KL_W-1:0] rand_kill_id();
        return KL_W'($urandom);
    endfunction

    function automatic logic [EL_W-1:0] rand_elapsed();
        return EL_W'($urandom);
    endfunction

    // Close the gap left by a removed entry
    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < shadow_count; k++) begin
            shadow_remaining[k] = shadow_remaining[k + 1];
            shadow_ident[k]     = shadow_ident[k + 1];
        end
        shadow_count--;
    endfunction

    // Apply one accepted request to the shadow queue and queue up its results
    function automatic void predict_timer_results(stq_pkg::in_item_t req);
        stq_pkg::out_item_t res;
        stq_pkg::out_item_t fired [$];
        longint             aged;
        int                 pos;
        bit                 hit;

        res = '0;
        res.last = 1'b1;
        case (req.operation)
            stq_pkg::OP_INSTALL: begin
                if (shadow_count >= DEPTH) begin
                    res.status = stq_pkg::STAT_FULL;
                    pending_results.push_back(res);
                end else begin
                    pos = 0;
                    while (pos < shadow_count
                           && shadow_remaining[pos] < int'(req.interval))
                        pos++;
                    for (int k = shadow_count; k > pos; k--) begin
                        shadow_remaining[k] = shadow_remaining[k - 1];
                        shadow_ident[k]     = shadow_ident[k - 1];
                    end
                    shadow_remaining[pos] = int'(req.interval);
                    shadow_ident[pos]     = shadow_next_id;
                    shadow_count++;
                    res.status      = stq_pkg::STAT_INSTALLED;
                    res.timer_ident = shadow_next_id;
                    pending_results.push_back(res);
                    shadow_next_id++;
                end
            end
            stq_pkg::OP_KILL: begin
                hit = 1'b0;
                pos = 0;
                while (pos < shadow_count) begin
                    if (shadow_ident[pos] == req.kill_id) begin
                        drop_entry(pos);
                        hit = 1'b1;
                    end else begin
                        pos++;
                    end
                end
                res.status      = hit ? stq_pkg::STAT_KILLED : stq_pkg::STAT_NOT_FOUND;
                res.timer_ident = req.kill_id;
                pending_results.push_back(res);
            end
            stq_pkg::OP_TICK: begin
                // Age every entry, saturating at the signed floor
                for (int k = 0; k < shadow_count; k++) begin
                    aged = longint'(shadow_remaining[k]) - longint'(req.elapsed);
                    if (aged < TIME_FLOOR)
                        aged = TIME_FLOOR;
                    shadow_remaining[k] = int'(aged);
                end
                // Pop expired heads in queue order
                while (shadow_count > 0 && shadow_remaining[0] <= 0
                       && fired.size() < DEPTH) begin
                    res.status      = stq_pkg::STAT_EXPIRED;
                    res.timer_ident = shadow_ident[0];
                    res.last        = 1'b0;
                    fired.push_back(res);
                    drop_entry(0);
                end
                if (fired.size() == 0) begin
                    res.status = stq_pkg::STAT_NONE;
                    pending_results.push_back(res);
                end else begin
                    fired[fired.size() - 1].last = 1'b1;
                    foreach (fired[k])
                        pending_results.push_back(fired[k]);
                end
            end
            default: begin
                // unused operation: dropped, no result
            end
        endcase
    endfunction

    function automatic void add_request(stq_pkg::op_t op, logic [IV_W-1:0] interval,
                                        logic [KL_W-1:0] kill_id,
                                        logic [EL_W-1:0] elapsed);
        stq_pkg::in_item_t req;
        req.operation = op;
        req.interval  = interval;
        req.kill_id   = kill_id;
        req.elapsed   = elapsed;
        request_queue.push_back(req);
    endfunction

    // Mostly well-formed traffic: kills aim at recently issued ids, ticks are short
    function automatic void queue_random_requests(int count, int install_pct);
        int              roll;
        logic [IV_W-1:0] interval;
        logic [KL_W-1:0] kill_id;
        logic [EL_W-1:0] elapsed;

        for (int n = 0; n < count; n++) begin
            roll     = $urandom_range(0, 99);
            interval = rand_interval();
            kill_id  = rand_kill_id();
            elapsed  = rand_elapsed();
            if (roll < install_pct) begin
                case ($urandom_range(0, 9))
                    7:       interval = rand_interval();
                    8:       interval = '0;
                    9:       interval = recent_interval;
                    default: interval = IV_W'($urandom_range(0, 1000));
                endcase
                recent_interval = interval;
                guess_next_id++;
                add_request(stq_pkg::OP_INSTALL, interval, kill_id, elapsed);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    if ($urandom_range(0, 4) != 0)
                        kill_id = guess_next_id - ID_W'($urandom_range(1, 8));
                    add_request(stq_pkg::OP_KILL, interval, kill_id, elapsed);
                end else if (roll < 90) begin
                    if ($urandom_range(0, 9) != 0)
                        elapsed = EL_W'($urandom_range(0, 300));
                    add_request(stq_pkg::OP_TICK, interval, kill_id, elapsed);
                end else begin
                    add_request(stq_pkg::OP_UNUSED, interval, kill_id, elapsed);
                end
            end
        end
    endfunction

    // Hold until every request is taken and every result has come back
    task automatic wait_quiet();
        while (request_queue.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Request driver: predict on acceptance, then offer the next request or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_timer_results(s_payload);
                accepted_requests++;
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_payload <= request_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_trigger) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= result_stall_pct);
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : result_check
        stq_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            checked_results++;
            if (m_payload.status == stq_pkg::STAT_FULL)
                full_answers++;
            if (m_payload.status == stq_pkg::STAT_EXPIRED)
                expiries++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d ident=%0d last=%0d",
                             $realtime, m_payload.status, m_payload.timer_ident,
                             m_payload.last);
            end else begin
                want = pending_results.pop_front();
                if (want.status !== m_payload.status
                    || want.timer_ident !== m_payload.timer_ident
                    || want.last !== m_payload.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch expected status=%0d ident=%0d last=%0d,",
                                  " got status=%0d ident=%0d last=%0d"},
                                 $realtime, want.status, want.timer_ident, want.last,
                                 m_payload.status, m_payload.timer_ident, m_payload.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue, unused code, equal intervals, extremes, fill and flush
        add_request(stq_pkg::OP_UNUSED, rand_interval(), rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_TICK, rand_interval(), rand_kill_id(), '0);
        add_request(stq_pkg::OP_KILL, rand_interval(), '0, rand_elapsed());
        add_request(stq_pkg::OP_INSTALL, '0, rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_INSTALL, INTERVAL_MAX, rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_INSTALL, IV_W'(5), rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_INSTALL, IV_W'(5), rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_TICK, rand_interval(), rand_kill_id(), '0);
        add_request(stq_pkg::OP_KILL, rand_interval(), KL_W'(2), rand_elapsed());
        add_request(stq_pkg::OP_KILL, rand_interval(), KILL_ID_MAX, rand_elapsed());
        for (int n = 0; n < DEPTH - 2; n++)
            add_request(stq_pkg::OP_INSTALL, rand_interval(), rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_INSTALL, rand_interval(), rand_kill_id(), rand_elapsed());
        add_request(stq_pkg::OP_TICK, rand_interval(), rand_kill_id(), ELAPSED_MAX);
        wait_quiet();

        // Random traffic under each idle mix
        guess_next_id = shadow_next_id;
        queue_random_requests(28, 45);
        wait_quiet();

        sender_idle_pct <= 52;
        queue_random_requests(28, 45);
        wait_quiet();

        sender_idle_pct  <= 0;
        result_stall_pct <= 52;
        queue_random_requests(28, 45);
        wait_quiet();

        sender_idle_pct  <= 28;
        result_stall_pct <= 28;
        queue_random_requests(28, 45);
        wait_quiet();

        // Long receiver hold-off while installs keep coming
        sender_idle_pct  <= 0;
        result_stall_pct <= 0;
        @(posedge aclk);
        hold_trigger <= 1'b1;
        @(posedge aclk);
        hold_trigger <= 1'b0;
        queue_random_requests(24, 80);
        wait_quiet();

        $display("Run covered %0d requests and %0d results over idle and stall mixes,",
                 accepted_requests, checked_results);
        $display("%0d full answers, %0d expiries, a full queue flush and a long hold-off.",
                 full_answers, expiries);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
